/* sv/hsc_pkg.sv */
// ----------------------------------------------------------------------------
// hsc_pkg
// shared constants, types and byte classing for the hostname syntax checker
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned TotalW = 8;
  localparam int unsigned LabelW = 7;

  localparam logic [CharW-1:0]  ChTerm   = 8'h00;
  localparam logic [CharW-1:0]  ChHyphen = 8'h2D;
  localparam logic [CharW-1:0]  ChDot    = 8'h2E;

  localparam logic [TotalW-1:0] MaxNameLen  = 8'd253;
  localparam logic [TotalW-1:0] NameLenSat  = 8'd254;
  localparam logic [LabelW-1:0] MaxLabelLen = 7'd63;

  // verdict for one finished name
  typedef struct packed {
    logic              valid_res;
    logic [TotalW-1:0] name_length;
  } hsc_verdict_t;

  // ascii letter or digit
  function automatic logic is_alnum(input logic [CharW-1:0] c);
    logic digit;
    logic upper;
    logic lower;
    digit = (c >= 8'h30) && (c <= 8'h39);
    upper = (c >= 8'h41) && (c <= 8'h5A);
    lower = (c >= 8'h61) && (c <= 8'h7A);
    return digit || upper || lower;
  endfunction

endpackage

/* sv/hsc_scan.sv */
// ----------------------------------------------------------------------------
// hsc_scan
// per-name scan state: byte and label counters, hyphen and error flags
// ----------------------------------------------------------------------------
module hsc_scan
  import hsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,     // byte leaves the input register
  input  logic [CharW-1:0]   char_i,
  output hsc_verdict_t       verdict_o   // meaningful when char_i is the terminator
);

  logic [TotalW-1:0] total_q, total_d;
  logic [LabelW-1:0] label_q, label_d;
  logic              hyph_q, hyph_d;
  logic              err_q, err_d;

  logic              is_term;
  logic              is_dot;
  logic              is_hyph;
  logic              close_err;
  logic [LabelW-1:0] label_inc;

  assign is_term   = (char_i == ChTerm);
  assign is_dot    = (char_i == ChDot);
  assign is_hyph   = (char_i == ChHyphen);
  assign close_err = (label_q == '0) || hyph_q;
  assign label_inc = (label_q <= MaxLabelLen) ? label_q + LabelW'(1) : label_q;

  assign verdict_o.valid_res   = !(err_q || close_err || (total_q == '0) ||
                                   (total_q > MaxNameLen));
  assign verdict_o.name_length = total_q;

  always_comb begin
    total_d = total_q;
    label_d = label_q;
    hyph_d  = hyph_q;
    err_d   = err_q;
    if (step_i) begin
      priority if (is_term) begin
        total_d = '0;
        label_d = '0;
        hyph_d  = 1'b0;
        err_d   = 1'b0;
      end else if (is_dot) begin
        total_d = (total_q <= MaxNameLen) ? total_q + TotalW'(1) : total_q;
        label_d = '0;
        hyph_d  = 1'b0;
        err_d   = err_q || close_err;
      end else begin
        total_d = (total_q <= MaxNameLen) ? total_q + TotalW'(1) : total_q;
        label_d = label_inc;
        hyph_d  = is_hyph;
        err_d   = err_q || !(is_alnum(char_i) || is_hyph) ||
                  (is_hyph && (label_q == '0)) || (label_inc > MaxLabelLen);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      label_q <= '0;
      hyph_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      total_q <= total_d;
      label_q <= label_d;
      hyph_q  <= hyph_d;
      err_q   <= err_d;
    end
  end

endmodule

/* sv/hostname_syntax_checker_unit.sv */
// ----------------------------------------------------------------------------
// hostname_syntax_checker_unit
// streaming hostname syntax check, one byte per transfer, one verdict per name
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   8      char_code, a zero byte ends the name
//  m_axis    out  16     valid_res [0], name_length [8:1], zeros above
//
//  one byte per cycle sustained unless a terminator stalls; a byte is held
//  in the input register and a verdict appears in the output register the
//  cycle after its terminator steps out; reset (rst_ni low, asynchronous)
//  empties both registers and clears the scan state, so the first byte
//  after reset starts a new name; only a terminator waits on a full, stalled
//  output register; other bytes keep flowing while a verdict waits to be taken
// ----------------------------------------------------------------------------
module hostname_syntax_checker_unit
  import hsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] valid_res, [8:1] name_length, [15:9] zero
);

  // input register
  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] in_char_q;

  // result register
  logic             out_valid_q, out_valid_d;
  hsc_verdict_t     out_q;

  hsc_verdict_t     verdict;
  logic             in_term;
  logic             out_free;
  logic             step;

  assign in_term  = (in_char_q == ChTerm);
  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;
  // the held byte leaves unless it is a terminator facing a full output
  assign step     = in_valid_q && (!in_term || out_free);

  assign s_axis_tready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
    end
  end

  hsc_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .char_i    (in_char_q),
    .verdict_o (verdict)
  );

  // a verdict is loaded only when a terminator steps
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (step && in_term) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_term) begin
      out_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.name_length, out_q.valid_res};

  // a new verdict only ever follows a terminator leaving the input register
  a_verdict_from_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q && in_term))
    else $error("verdict appeared without a terminator");

  // the reported length never passes the saturation value
  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.name_length <= NameLenSat))
    else $error("name length beyond saturation");

  // a valid name has a length within the allowed range
  a_valid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.valid_res) |->
      ((out_q.name_length != '0) && (out_q.name_length <= MaxNameLen)))
    else $error("valid verdict with illegal length");

  // a refused byte only ever means a terminator in the input register facing a full output
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_term && out_valid_q))
    else $error("input stalled without a blocked terminator");

endmodule
